@@ rtl/lfs_pkg.sv @@
// types and constants shared by the line-follow steering block
// no dependencies; imported by lfs_steer_fsm and line_follow_steering_fsm_top
package lfs_pkg;

    localparam int SPEED_W = 10;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd500;

    typedef enum logic [2:0] {
        MODE_CRUISE     = 3'd0,
        MODE_LEFT       = 3'd1,
        MODE_RIGHT      = 3'd2,
        MODE_REAR_LEFT  = 3'd3,
        MODE_REAR_RIGHT = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_FWD  = 2'd1,
        ACT_BACK = 2'd2,
        ACT_STOP = 2'd3
    } action_t;

    typedef struct packed {
        logic rear_right;
        logic rear_left;
        logic center;
        logic far_right;
        logic mid_right;
        logic inner_right;
        logic inner_left;
        logic mid_left;
        logic far_left;
    } sensors_t;

    typedef struct packed {
        mode_t               steer_mode;
        logic [SPEED_W-1:0]  right_speed;
        action_t             right_action;
        logic [SPEED_W-1:0]  left_speed;
        action_t             left_action;
    } cmd_t;

endpackage

@@ rtl/lfs_steer_fsm.sv @@
// steering mode register and per-sample wheel command decision
// depends on lfs_pkg
module lfs_steer_fsm
    import lfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  sensors_t           sens,
    input  logic [SPEED_W-1:0] speed,
    output cmd_t               cmd
);

    mode_t mode_reg;
    mode_t mode_next;

    logic crossing;

    assign crossing = sens.center
                    | (sens.far_left & sens.far_right)
                    | (sens.mid_left & sens.mid_right)
                    | (sens.inner_left & sens.inner_right);

    // next mode
    always_comb
    begin
        mode_next = MODE_CRUISE;
        case (mode_reg)
            MODE_REAR_LEFT:
            begin
                mode_next = (sens.inner_left | sens.rear_right) ? MODE_CRUISE : MODE_REAR_LEFT;
            end
            MODE_REAR_RIGHT:
            begin
                mode_next = (sens.inner_right | sens.rear_left) ? MODE_CRUISE : MODE_REAR_RIGHT;
            end
            MODE_LEFT:
            begin
                mode_next = (sens.center | sens.far_right) ? MODE_CRUISE : MODE_LEFT;
            end
            MODE_RIGHT:
            begin
                mode_next = (sens.center | sens.far_left) ? MODE_CRUISE : MODE_RIGHT;
            end
            default:
            begin
                if (crossing)
                    mode_next = MODE_CRUISE;
                else if (sens.far_left)
                    mode_next = MODE_LEFT;
                else if (sens.far_right)
                    mode_next = MODE_RIGHT;
                else if (sens.mid_left | sens.mid_right | sens.inner_left | sens.inner_right)
                    mode_next = MODE_CRUISE;
                else if (sens.rear_left & ~sens.rear_right)
                    mode_next = MODE_REAR_LEFT;
                else if (sens.rear_right & ~sens.rear_left)
                    mode_next = MODE_REAR_RIGHT;
                else
                    mode_next = MODE_CRUISE;
            end
        endcase
    end

    // wheel commands
    always_comb
    begin
        cmd.left_action  = ACT_HOLD;
        cmd.left_speed   = '0;
        cmd.right_action = ACT_HOLD;
        cmd.right_speed  = '0;
        cmd.steer_mode   = mode_next;
        case (mode_reg)
            MODE_REAR_LEFT:
            begin
                cmd.left_action  = ACT_BACK;
                cmd.left_speed   = speed;
                cmd.right_action = ACT_FWD;
                cmd.right_speed  = speed;
            end
            MODE_REAR_RIGHT:
            begin
                cmd.left_action  = ACT_FWD;
                cmd.left_speed   = speed;
                cmd.right_action = ACT_BACK;
                cmd.right_speed  = speed;
            end
            MODE_LEFT:
            begin
                cmd.left_action  = ACT_STOP;
                cmd.left_speed   = speed;
                cmd.right_action = ACT_FWD;
                cmd.right_speed  = speed;
            end
            MODE_RIGHT:
            begin
                cmd.left_action  = ACT_FWD;
                cmd.left_speed   = speed;
                cmd.right_action = ACT_STOP;
                cmd.right_speed  = speed;
            end
            default:
            begin
                if (crossing)
                begin
                    cmd.left_action  = ACT_FWD;
                    cmd.left_speed   = speed;
                    cmd.right_action = ACT_FWD;
                    cmd.right_speed  = speed;
                end
                else if (sens.far_left | sens.far_right)
                begin
                    cmd.left_action  = ACT_HOLD;
                    cmd.right_action = ACT_HOLD;
                end
                else if (sens.mid_left)
                begin
                    cmd.left_action  = ACT_BACK;
                    cmd.left_speed   = speed;
                    cmd.right_action = ACT_FWD;
                    cmd.right_speed  = speed;
                end
                else if (sens.mid_right)
                begin
                    cmd.left_action  = ACT_FWD;
                    cmd.left_speed   = speed;
                    cmd.right_action = ACT_BACK;
                    cmd.right_speed  = speed;
                end
                else if (sens.inner_left)
                begin
                    // light turn: stop at zero speed
                    cmd.left_action  = ACT_STOP;
                    cmd.right_action = ACT_FWD;
                    cmd.right_speed  = speed;
                end
                else if (sens.inner_right)
                begin
                    cmd.left_action  = ACT_FWD;
                    cmd.left_speed   = speed;
                    cmd.right_action = ACT_STOP;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_CRUISE;
        else if (step_en)
            mode_reg <= mode_next;
    end

endmodule

@@ rtl/line_follow_steering_fsm_top.sv @@
// line-follow steering block: input register, steering decision, result register
// depends on lfs_pkg and lfs_steer_fsm
//
// usage:
//   s_axis carries one sensor sample per request; m_axis returns one wheel
//   command per sample, in order. cfg_wr_en/cfg_wr_data load drive_speed and
//   must be written only while the block is idle; the block does not enforce it.
//   a sample is registered in the input stage on acceptance and decided by the
//   steering fsm; its command is loaded into the result register once the
//   result stage can take it, and m_axis shows it from there.
//   throughput is one sample per cycle while the receiver does not stall; the
//   mode register closes its loop through the decision logic alone.
//   reset clears both stage valids, puts the mode in cruise and drive_speed
//   to 500.
//   when the receiver stalls, the result register holds, the input stage
//   fills, and s_axis_tready drops; nothing is lost or repeated.
module line_follow_steering_fsm_top
    import lfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // far_left, mid_left, inner_left, inner_right, mid_right, far_right,
    // center, rear_left, rear_right, then zero fill
    input  logic [15:0]        s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // left_action, left_speed, right_action, right_speed, steer_mode, then zero fill
    output logic [31:0]        m_axis_tdata,
    input  logic               cfg_wr_en,
    input  logic [SPEED_W-1:0] cfg_wr_data
);

    logic               in_valid_reg;
    sensors_t           in_sens_reg;
    logic               out_valid_reg;
    cmd_t               out_cmd_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic out_ready;
    logic step_en;
    cmd_t cmd;

    assign out_ready     = ~out_valid_reg | m_axis_tready;
    assign step_en       = in_valid_reg & out_ready;
    assign s_axis_tready = ~in_valid_reg | out_ready;

    lfs_steer_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .sens    (in_sens_reg),
        .speed   (speed_reg),
        .cmd     (cmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else if (cfg_wr_en)
            speed_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid & s_axis_tready)
            in_sens_reg <= sensors_t'(s_axis_tdata[8:0]);
        if (step_en)
            out_cmd_reg <= cmd;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_cmd_reg};

endmodule

@@ tb/line_follow_steering_fsm_top_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for line_follow_steering_fsm_top: directed table then random samples
// depends on lfs_pkg and the rtl of line_follow_steering_fsm_top
module line_follow_steering_fsm_top_tb;
    import lfs_pkg::*;

    localparam logic [8:0] S_FL = 9'h001;
    localparam logic [8:0] S_ML = 9'h002;
    localparam logic [8:0] S_IL = 9'h004;
    localparam logic [8:0] S_IR = 9'h008;
    localparam logic [8:0] S_MR = 9'h010;
    localparam logic [8:0] S_FR = 9'h020;
    localparam logic [8:0] S_CE = 9'h040;
    localparam logic [8:0] S_RL = 9'h080;
    localparam logic [8:0] S_RR = 9'h100;
    localparam logic [SPEED_W-1:0] V = SPEED_RESET;
    localparam int RANDOM_PER_SPEED = 150;

    typedef struct {
        logic [8:0] sample;
        bit         typed;
        cmd_t       want;
    } sample_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;
    logic               cfg_wr_en;
    logic [SPEED_W-1:0] cfg_wr_data;

    mode_t              steer_state;
    logic [SPEED_W-1:0] speed_setting;
    cmd_t               wheel_cmds_due[$];
    sample_row_t        sample_plan[$];
    int                 errors;
    bit                 tx_burst;
    bit                 rx_burst;
    logic [SPEED_W-1:0] speed_list[5];

    line_follow_steering_fsm_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cmd_t wheel_cmd(action_t la, logic [SPEED_W-1:0] ls, action_t ra,
                                       logic [SPEED_W-1:0] rs, mode_t m);
        cmd_t c;
        c.left_action  = la;
        c.left_speed   = ls;
        c.right_action = ra;
        c.right_speed  = rs;
        c.steer_mode   = m;
        return c;
    endfunction

    function automatic cmd_t steer_decide(sensors_t s);
        action_t            la;
        action_t            ra;
        logic [SPEED_W-1:0] ls;
        logic [SPEED_W-1:0] rs;
        mode_t              nxt;
        la  = ACT_HOLD;
        ra  = ACT_HOLD;
        ls  = '0;
        rs  = '0;
        nxt = steer_state;
        case (steer_state)
            MODE_REAR_LEFT:
            begin
                la = ACT_BACK; ls = speed_setting; ra = ACT_FWD; rs = speed_setting;
                if (s.inner_left || s.rear_right)
                    nxt = MODE_CRUISE;
            end
            MODE_REAR_RIGHT:
            begin
                ra = ACT_BACK; rs = speed_setting; la = ACT_FWD; ls = speed_setting;
                if (s.inner_right || s.rear_left)
                    nxt = MODE_CRUISE;
            end
            MODE_LEFT:
            begin
                la = ACT_STOP; ls = speed_setting; ra = ACT_FWD; rs = speed_setting;
                if (s.center || s.far_right)
                    nxt = MODE_CRUISE;
            end
            MODE_RIGHT:
            begin
                ra = ACT_STOP; rs = speed_setting; la = ACT_FWD; ls = speed_setting;
                if (s.center || s.far_left)
                    nxt = MODE_CRUISE;
            end
            default:
            begin
                nxt = MODE_CRUISE;
                if (s.center || (s.far_left && s.far_right) || (s.mid_left && s.mid_right)
                    || (s.inner_left && s.inner_right))
                begin
                    la = ACT_FWD; ls = speed_setting; ra = ACT_FWD; rs = speed_setting;
                end
                else if (s.far_left)
                    nxt = MODE_LEFT;
                else if (s.far_right)
                    nxt = MODE_RIGHT;
                else if (s.mid_left)
                begin
                    la = ACT_BACK; ls = speed_setting; ra = ACT_FWD; rs = speed_setting;
                end
                else if (s.mid_right)
                begin
                    ra = ACT_BACK; rs = speed_setting; la = ACT_FWD; ls = speed_setting;
                end
                else if (s.inner_left)
                begin
                    la = ACT_STOP; ls = '0; ra = ACT_FWD; rs = speed_setting;
                end
                else if (s.inner_right)
                begin
                    ra = ACT_STOP; rs = '0; la = ACT_FWD; ls = speed_setting;
                end
                else if (s.rear_left && !s.rear_right)
                    nxt = MODE_REAR_LEFT;
                else if (s.rear_right && !s.rear_left)
                    nxt = MODE_REAR_RIGHT;
            end
        endcase
        steer_state = nxt;
        return wheel_cmd(la, ls, ra, rs, nxt);
    endfunction

    function automatic sensors_t random_sample();
        logic [8:0] bits;
        int         pick;
        int         dens;
        bits = '0;
        if ($urandom_range(0, 3) == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 9)
                bits[pick] = 1'b1;
        end
        else
        begin
            dens = 2 << $urandom_range(0, 2);
            for (int i = 0; i < 9; i++)
                bits[i] = ($urandom_range(0, 15) < dens);
        end
        return sensors_t'(bits);
    endfunction

    task automatic add_step(logic [8:0] sample, bit typed, cmd_t want);
        sample_row_t row;
        row.sample = sample;
        row.typed  = typed;
        row.want   = want;
        sample_plan.push_back(row);
    endtask

    task automatic report_error(string what, int got, int want);
        if (errors < 100)
            $display("%0t: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // valid stays high across back-to-back requests
    task automatic send_sample(sensors_t s, bit typed, cmd_t typed_cmd);
        int   gap;
        cmd_t want;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, s};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = steer_decide(s);
        if (typed)
            want = typed_cmd;
        wheel_cmds_due.push_back(want);
    endtask

    task automatic set_drive_speed(logic [SPEED_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (wheel_cmds_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        speed_setting = value;
    endtask

    // receiver: random stall before each request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        rx_burst      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cmd_t got;
        cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[26:0];
            if (wheel_cmds_due.size() == 0)
                report_error("unexpected command", m_axis_tdata, 0);
            else
            begin
                want = wheel_cmds_due.pop_front();
                if (got.left_action !== want.left_action)
                    report_error("left_action", got.left_action, want.left_action);
                if (got.left_speed !== want.left_speed)
                    report_error("left_speed", got.left_speed, want.left_speed);
                if (got.right_action !== want.right_action)
                    report_error("right_action", got.right_action, want.right_action);
                if (got.right_speed !== want.right_speed)
                    report_error("right_speed", got.right_speed, want.right_speed);
                if (got.steer_mode !== want.steer_mode)
                    report_error("steer_mode", got.steer_mode, want.steer_mode);
                if (m_axis_tdata[31:27] !== 5'd0)
                    report_error("tdata fill", m_axis_tdata[31:27], 0);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("line_follow_steering_fsm_top: mismatch");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        errors        = 0;
        tx_burst      = 1'b0;
        steer_state   = MODE_CRUISE;
        speed_setting = SPEED_RESET;
        speed_list    = '{10'h3FF, 10'h000, 10'h2AA, 10'h155, 10'h000};
        speed_list[4] = SPEED_W'($urandom_range(0, 1023));

        add_step(9'h000, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_CRUISE));
        add_step(S_CE, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_FL | S_FR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_ML | S_MR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_IL | S_IR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_FL, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_LEFT));
        add_step(9'h000, 1'b1, wheel_cmd(ACT_STOP, V, ACT_FWD, V, MODE_LEFT));
        add_step(S_FR, 1'b1, wheel_cmd(ACT_STOP, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_FR, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_RIGHT));
        add_step(S_FL, 1'b1, wheel_cmd(ACT_FWD, V, ACT_STOP, V, MODE_CRUISE));
        add_step(S_ML, 1'b1, wheel_cmd(ACT_BACK, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_MR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_BACK, V, MODE_CRUISE));
        add_step(S_IL, 1'b1, wheel_cmd(ACT_STOP, '0, ACT_FWD, V, MODE_CRUISE));
        add_step(S_IR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_STOP, '0, MODE_CRUISE));
        add_step(S_RL, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_REAR_LEFT));
        add_step(S_RR, 1'b1, wheel_cmd(ACT_BACK, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_RR, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_REAR_RIGHT));
        add_step(S_IR, 1'b1, wheel_cmd(ACT_FWD, V, ACT_BACK, V, MODE_CRUISE));
        add_step(S_RL | S_RR, 1'b1, wheel_cmd(ACT_HOLD, '0, ACT_HOLD, '0, MODE_CRUISE));
        add_step(9'h1FF, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_FL | S_CE, 1'b1, wheel_cmd(ACT_FWD, V, ACT_FWD, V, MODE_CRUISE));
        add_step(S_FL | S_RL, 1'b0, '0);
        add_step(S_CE, 1'b0, '0);
        add_step(S_RR, 1'b0, '0);
        add_step(S_RL, 1'b0, '0);
        add_step(S_RL, 1'b0, '0);
        add_step(S_IL, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (sample_plan[i])
            send_sample(sensors_t'(sample_plan[i].sample), sample_plan[i].typed,
                        sample_plan[i].want);

        foreach (speed_list[p])
        begin
            set_drive_speed(speed_list[p]);
            repeat (RANDOM_PER_SPEED)
                send_sample(random_sample(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (wheel_cmds_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("line_follow_steering_fsm_top: match");
        else
            $display("line_follow_steering_fsm_top: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/lfs_pkg.sv
rtl/lfs_steer_fsm.sv
rtl/line_follow_steering_fsm_top.sv
tb/line_follow_steering_fsm_top_tb.sv
